// ----- rtl/hcrf_pkg.sv -----
package hcrf_pkg;

	localparam int NUM_BINS  = 256;
	localparam int BIN_W     = 8;
	localparam int CLIP_W    = 15;
	localparam int CLIP_FULL = 25600;
	localparam int SCALE_Q   = 51200;
	localparam int SCALE_W   = 16;

	// One queued pixel word between the front and the back.
	typedef struct packed {
		logic [BIN_W-1:0] gray;
		logic             last;
	} pix_word_t;

	// Back-end control states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_MUL,
		ST_SCAN,
		ST_OUT
	} back_state_t;

	// One result word.
	typedef struct packed {
		logic [BIN_W-1:0] low_gray;
		logic [BIN_W-1:0] high_gray;
		logic             high_cut_underflow;
	} result_t;

endpackage

// ----- rtl/hcrf_if.sv -----
interface hcrf_pix_if;
	logic                         valid;
	logic                         ready;
	logic [hcrf_pkg::BIN_W-1:0]   gray_pixel;
	logic                         last_pixel;
	modport source (output valid, gray_pixel, last_pixel, input ready);
	modport sink (input valid, gray_pixel, last_pixel, output ready);
endinterface

interface hcrf_res_if;
	logic                         valid;
	logic                         ready;
	logic [hcrf_pkg::BIN_W-1:0]   low_gray;
	logic [hcrf_pkg::BIN_W-1:0]   high_gray;
	logic                         high_cut_underflow;
	modport source (output valid, low_gray, high_gray, high_cut_underflow, input ready);
	modport sink (input valid, low_gray, high_gray, high_cut_underflow, output ready);
endinterface

// ----- rtl/hcrf_fifo.sv -----
// Short queue of pixel words between the front and the back.
module hcrf_fifo #(
	parameter int DEPTH_LOG2 = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hcrf_pkg::pix_word_t push_word,
	output logic                full,
	input  logic                pop,
	output hcrf_pkg::pix_word_t pop_word,
	output logic                empty
);
	localparam int DEPTH = 1 << DEPTH_LOG2;

	hcrf_pkg::pix_word_t     mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0]   wr_q;
	logic [DEPTH_LOG2-1:0]   rd_q;
	logic [DEPTH_LOG2:0]     cnt_q;

	assign full     = cnt_q == (DEPTH_LOG2+1)'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_word = mem_q[rd_q];

	// Storage is written without reset.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (DEPTH_LOG2+1)'(push) - (DEPTH_LOG2+1)'(pop);
		end
	end
endmodule

// ----- rtl/hcrf_back.sv -----
// Histogram update, frame-end cut search and bin clearing.
module hcrf_back #(
	parameter int COUNT_WIDTH = 23
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [hcrf_pkg::CLIP_W-1:0] clip_q,
	input  logic                    q_empty,
	input  hcrf_pkg::pix_word_t     q_word,
	output logic                    q_pop,
	output logic                    busy,
	output logic                    res_valid,
	input  logic                    res_ready,
	output hcrf_pkg::result_t       res
);
	localparam int CW   = COUNT_WIDTH;
	localparam int PW   = hcrf_pkg::CLIP_W + CW;
	localparam int SW   = CW + hcrf_pkg::SCALE_W;
	localparam logic [CW-1:0] CMAX = '1;
	localparam int BW   = hcrf_pkg::BIN_W;

	// Histogram memory, one read and one write port.
	logic [CW-1:0] bins_mem [hcrf_pkg::NUM_BINS];
	logic [CW-1:0] rd_data_q;
	logic [BW-1:0] rd_addr;
	logic          wr_en;
	logic [BW-1:0] wr_addr;
	logic [CW-1:0] wr_data;

	hcrf_pkg::back_state_t state_q, state_d;
	logic [BW-1:0]  addr_q;
	logic           last_q;
	logic [BW-1:0]  min_q, max_q;
	logic [CW-1:0]  total_q;
	logic [CW-1:0]  cum_q;
	logic [PW-1:0]  share_q;
	logic [SW-1:0]  full_q;
	logic           lo_found_q;
	logic [BW-1:0]  lo_q, hi_q;
	logic           hi_found_q;
	logic           scan_rd_q;
	hcrf_pkg::result_t res_q;
	logic           valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) bins_mem[wr_addr] <= wr_data;
		rd_data_q <= bins_mem[rd_addr];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hcrf_pkg::ST_CLEAR: if (addr_q == '1) state_d = hcrf_pkg::ST_IDLE;
			hcrf_pkg::ST_IDLE:  if (!q_empty) state_d = hcrf_pkg::ST_RMW;
			hcrf_pkg::ST_RMW: begin
				if (!last_q) state_d = hcrf_pkg::ST_IDLE;
				else if (clip_q == '0) state_d = hcrf_pkg::ST_OUT;
				else state_d = hcrf_pkg::ST_MUL;
			end
			hcrf_pkg::ST_MUL:   state_d = hcrf_pkg::ST_SCAN;
			hcrf_pkg::ST_SCAN:  if (scan_rd_q && addr_q == '1) state_d = hcrf_pkg::ST_OUT;
			hcrf_pkg::ST_OUT:   if (!valid_q) state_d = hcrf_pkg::ST_CLEAR;
			default:            state_d = hcrf_pkg::ST_CLEAR;
		endcase
	end

	// Saturated bin value and running cumulative sum.
	logic [CW-1:0] bin_inc;
	logic [CW:0]   cum_sum;
	logic [CW-1:0] cum_next;
	logic [SW-1:0] cum_scaled;
	assign bin_inc  = (rd_data_q == CMAX) ? rd_data_q : rd_data_q + 1'b1;
	assign cum_sum  = {1'b0, cum_q} + {1'b0, rd_data_q};
	assign cum_next = cum_sum[CW] ? CMAX : cum_sum[CW-1:0];
	assign cum_scaled = SW'(cum_next) * SW'(hcrf_pkg::SCALE_Q);
	logic lo_hit, hi_hit;
	assign lo_hit = (SW+1)'(cum_scaled) >= (SW+1)'(share_q);
	assign hi_hit = (SW+1)'(cum_scaled) + (SW+1)'(share_q) < (SW+1)'(full_q);

	// Memory port control.
	always_comb begin
		rd_addr = q_word.gray;
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = bin_inc;
		q_pop   = 1'b0;
		unique case (state_q)
			hcrf_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
			end
			hcrf_pkg::ST_IDLE: q_pop = !q_empty;
			hcrf_pkg::ST_RMW:  wr_en = 1'b1;
			hcrf_pkg::ST_MUL:  rd_addr = '0;
			// The first scan cycle reads bin addr_q again so the data lines up.
			hcrf_pkg::ST_SCAN: rd_addr = scan_rd_q ? addr_q + 1'b1 : addr_q;
			default: ;
		endcase
	end

	assign busy      = state_q != hcrf_pkg::ST_IDLE || !q_empty;
	assign res_valid = valid_q;
	assign res       = res_q;

	// Sequencer registers and frame statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hcrf_pkg::ST_CLEAR;
			addr_q     <= '0;
			last_q     <= 1'b0;
			min_q      <= '1;
			max_q      <= '0;
			total_q    <= '0;
			cum_q      <= '0;
			share_q    <= '0;
			full_q     <= '0;
			lo_found_q <= 1'b0;
			hi_found_q <= 1'b0;
			lo_q       <= '1;
			hi_q       <= '0;
			scan_rd_q  <= 1'b0;
			valid_q    <= 1'b0;
			res_q      <= '0;
		end else begin
			state_q <= state_d;
			if (valid_q && res_ready) valid_q <= 1'b0;
			unique case (state_q)
				hcrf_pkg::ST_CLEAR: begin
					addr_q  <= addr_q + 1'b1;
					min_q   <= '1;
					max_q   <= '0;
					total_q <= '0;
				end
				hcrf_pkg::ST_IDLE: begin
					if (!q_empty) begin
						addr_q <= q_word.gray;
						last_q <= q_word.last;
						if (q_word.gray < min_q) min_q <= q_word.gray;
						if (q_word.gray > max_q) max_q <= q_word.gray;
						if (total_q != CMAX) total_q <= total_q + 1'b1;
					end
				end
				hcrf_pkg::ST_RMW: begin
					res_q.low_gray           <= min_q;
					res_q.high_gray          <= max_q;
					res_q.high_cut_underflow <= 1'b0;
				end
				hcrf_pkg::ST_MUL: begin
					// Clip share and full scale, both scaled by 51200.
					share_q <= PW'((clip_q > hcrf_pkg::CLIP_W'(hcrf_pkg::CLIP_FULL)) ?
						hcrf_pkg::CLIP_W'(hcrf_pkg::CLIP_FULL) : clip_q) * PW'(total_q);
					full_q     <= SW'(total_q) * SW'(hcrf_pkg::SCALE_Q);
					cum_q      <= '0;
					addr_q     <= '0;
					lo_found_q <= 1'b0;
					hi_found_q <= 1'b0;
					lo_q       <= '1;
					hi_q       <= '0;
					scan_rd_q  <= 1'b0;
				end
				hcrf_pkg::ST_SCAN: begin
					// rd_data_q holds bin addr_q once the first read lands.
					if (!scan_rd_q) begin
						scan_rd_q <= 1'b1;
					end else begin
						cum_q  <= cum_next;
						addr_q <= addr_q + 1'b1;
						if (!lo_found_q && lo_hit) begin
							lo_found_q <= 1'b1;
							lo_q       <= addr_q;
						end
						// The last bin meeting the condition wins.
						if (hi_hit) begin
							hi_found_q <= 1'b1;
							hi_q       <= addr_q;
						end
						if (addr_q == '1) begin
							res_q.low_gray <= (!lo_found_q && lo_hit) ? addr_q : lo_q;
							res_q.high_gray <= hi_hit ? addr_q : hi_q;
							res_q.high_cut_underflow <= !(hi_hit || hi_found_q);
						end
					end
				end
				hcrf_pkg::ST_OUT: begin
					if (!valid_q) begin
						addr_q <= '0;
					end
				end
				default: ;
			endcase
			if (state_q != hcrf_pkg::ST_OUT && state_d == hcrf_pkg::ST_OUT) valid_q <= 1'b1;
		end
	end
endmodule

// ----- rtl/histogram_clip_range_finder.sv -----
// Histogram clip range finder. Gray pixels enter one word at a time on pix;
// at the word marked last the block delivers one word on res with the low
// and high cut levels (or the frame minimum and maximum when the clip value
// is zero). Each pixel takes a read and a write of the histogram memory in
// the back end, and the next pixel is not taken from the queue until that
// write is done; a four-word queue absorbs short bursts. At the frame end the
// cut search reads all 256 bins, the result then waits in the output
// register until taken, and a clearing pass over all bins follows, as it
// also does after reset. The clip value must only be written while idle.
module histogram_clip_range_finder #(
	parameter int COUNT_WIDTH = 23
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [hcrf_pkg::CLIP_W-1:0]  cfg_wdata,
	hcrf_pix_if.sink                     pix,
	hcrf_res_if.source                   res
);
	logic [hcrf_pkg::CLIP_W-1:0] clip_q;
	logic                q_full, q_empty, q_pop, busy;
	hcrf_pkg::pix_word_t q_word, in_word;
	hcrf_pkg::result_t   res_w;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clip_q <= hcrf_pkg::CLIP_W'(256);
		else if (cfg_we) clip_q <= cfg_wdata;
	end

	// Front end: the queue accepts words while it has room.
	assign pix.ready     = !q_full;
	assign in_word.gray  = pix.gray_pixel;
	assign in_word.last  = pix.last_pixel;

	hcrf_fifo #(.DEPTH_LOG2(2)) u_fifo (
		.clk, .arst_n,
		.push(pix.valid && !q_full), .push_word(in_word), .full(q_full),
		.pop(q_pop), .pop_word(q_word), .empty(q_empty)
	);

	hcrf_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk, .arst_n, .clip_q,
		.q_empty, .q_word, .q_pop, .busy,
		.res_valid(res.valid), .res_ready(res.ready), .res(res_w)
	);

	assign res.low_gray           = res_w.low_gray;
	assign res.high_gray          = res_w.high_gray;
	assign res.high_cut_underflow = res_w.high_cut_underflow;

	// The queue never pops when empty.
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("pop from empty queue");
	// A pending result holds its value until taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res_w))
		else $error("result changed while stalled");
	// A result appears only while the back end is busy.
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> busy) else $error("result while idle");
endmodule

// ----- tb/sv/histogram_clip_range_finder_tb.sv -----
module histogram_clip_range_finder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_W = 23;
	localparam longint CNT_MAX = (64'd1 << CNT_W) - 1;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int SETTLE_CYCLES = 600;

	// Idle profiles, one per phase of the run.
	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [hcrf_pkg::CLIP_W-1:0] cfg_wdata = '0;

	hcrf_pix_if pix ();
	hcrf_res_if res ();

	histogram_clip_range_finder #(.COUNT_WIDTH(CNT_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pix(pix.sink),
		.res(res.source)
	);

	always #1 clk = ~clk;

	// Predictor state: a mirror of the block's frame statistics.
	longint hist_bins [hcrf_pkg::NUM_BINS];
	int frame_min;
	int frame_max;
	longint frame_count;
	int clip_q8;

	hcrf_pkg::result_t cuts_pending [$];
	int fail_count = 0;
	int word_count = 0;
	int result_count = 0;
	int frame_count_done = 0;
	longint cycle_count = 0;
	idle_mode_t idle_mode = IDLE_NONE;

	// Directed stimulus: gray level, last flag, and an optional typed-in result.
	typedef struct {
		logic [7:0]        gray;
		logic              last;
		logic              has_lit;
		hcrf_pkg::result_t lit;
	} dir_row_t;

	dir_row_t dir_rows [$];

	function automatic void clear_stats();
		foreach (hist_bins[i])
			hist_bins[i] = 0;
		frame_min = 255;
		frame_max = 0;
		frame_count = 0;
	endfunction

	// Account one pixel; return 1 and the cut levels at the frame end.
	function automatic bit predict_cuts(input logic [7:0] gray, input logic last,
			output hcrf_pkg::result_t cut);
		longint run;
		longint share;
		longint whole;
		longint csum [hcrf_pkg::NUM_BINS];
		longint p;
		if (hist_bins[gray] < CNT_MAX)
			hist_bins[gray]++;
		if (frame_count < CNT_MAX)
			frame_count++;
		if (gray < frame_min)
			frame_min = gray;
		if (gray > frame_max)
			frame_max = gray;
		if (!last)
			return 0;
		if (clip_q8 == 0) begin
			cut.low_gray = frame_min[7:0];
			cut.high_gray = frame_max[7:0];
			cut.high_cut_underflow = 1'b0;
		end else begin
			p = (clip_q8 > hcrf_pkg::CLIP_FULL) ? hcrf_pkg::CLIP_FULL : clip_q8;
			share = p * frame_count;
			whole = frame_count * hcrf_pkg::SCALE_Q;
			run = 0;
			for (int i = 0; i < hcrf_pkg::NUM_BINS; i++) begin
				run += hist_bins[i];
				if (run > CNT_MAX)
					run = CNT_MAX;
				csum[i] = run;
			end
			cut.low_gray = 8'd255;
			for (int i = 0; i < hcrf_pkg::NUM_BINS; i++) begin
				if (csum[i] * hcrf_pkg::SCALE_Q >= share) begin
					cut.low_gray = i[7:0];
					break;
				end
			end
			cut.high_gray = 8'd0;
			cut.high_cut_underflow = 1'b1;
			for (int i = hcrf_pkg::NUM_BINS - 1; i >= 0; i--) begin
				if (csum[i] * hcrf_pkg::SCALE_Q + share < whole) begin
					cut.high_gray = i[7:0];
					cut.high_cut_underflow = 1'b0;
					break;
				end
			end
		end
		clear_stats();
		return 1;
	endfunction

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit send_idles();
		return (idle_mode == IDLE_SEND) ? roll(68) : (idle_mode == IDLE_BOTH) ? roll(7) : 0;
	endfunction

	// Receiver stalls follow the current phase.
	always @(negedge clk) begin
		if (idle_mode == IDLE_RECV)
			res.ready <= !roll(68);
		else if (idle_mode == IDLE_BOTH)
			res.ready <= !roll(7);
		else
			res.ready <= 1'b1;
	end

	// Result checker: compare each accepted word with the oldest expectation.
	always @(posedge clk) begin
		hcrf_pkg::result_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && res.valid && res.ready) begin
			result_count <= result_count + 1;
			if (cuts_pending.size() == 0) begin
				$error("unexpected result word: low %0d high %0d", res.low_gray,
					res.high_gray);
				fail_count++;
			end else begin
				want = cuts_pending.pop_front();
				if (res.low_gray !== want.low_gray) begin
					$error("low_gray: expected %0d, got %0d", want.low_gray, res.low_gray);
					fail_count++;
				end
				if (res.high_gray !== want.high_gray) begin
					$error("high_gray: expected %0d, got %0d", want.high_gray,
						res.high_gray);
					fail_count++;
				end
				if (res.high_cut_underflow !== want.high_cut_underflow) begin
					$error("high_cut_underflow: expected %0d, got %0d",
						want.high_cut_underflow, res.high_cut_underflow);
					fail_count++;
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		if (cycle_count > LIMIT_CYCLES) begin
			$display("histogram_clip_range_finder test failed");
			$finish;
		end
	end

	// Drive one pixel word and wait for it to be taken.
	task automatic send_word(input logic [7:0] gray, input logic last,
			input logic has_lit, input hcrf_pkg::result_t lit);
		hcrf_pkg::result_t cut;
		while (send_idles()) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.gray_pixel <= gray;
		pix.last_pixel <= last;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		word_count++;
		if (predict_cuts(gray, last, cut)) begin
			frame_count_done++;
			if (has_lit && cut !== lit) begin
				$error("predictor disagrees with table: expected %p, got %p", lit, cut);
				fail_count++;
			end
			cuts_pending.push_back(has_lit ? lit : cut);
		end
		@(negedge clk);
	endtask

	// Wait until all results are in, then let the clearing pass finish.
	task automatic drain();
		pix.valid <= 1'b0;
		while (cuts_pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_clip(input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[hcrf_pkg::CLIP_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		clip_q8 = value & 32'h7FFF;
	endtask

	function automatic void add_row(input int gray, input bit last, input bit has_lit,
			input int lo = 0, input int hi = 0, input bit uf = 0);
		dir_row_t r;
		r.gray = gray[7:0];
		r.last = last;
		r.has_lit = has_lit;
		r.lit.low_gray = lo[7:0];
		r.lit.high_gray = hi[7:0];
		r.lit.high_cut_underflow = uf;
		dir_rows.push_back(r);
	endfunction

	// Random frame: mostly short frames, a few long ones, with varied shapes.
	task automatic random_frame();
		int len;
		int center;
		int spread;
		int shape;
		int g;
		hcrf_pkg::result_t none;
		none = '0;
		len = roll(5) ? $urandom_range(200, 60) : $urandom_range(12, 1);
		center = $urandom_range(255);
		spread = $urandom_range(255);
		shape = $urandom_range(2);
		for (int i = 0; i < len; i++) begin
			case (shape)
				0: g = $urandom_range(255);
				1: g = center + $urandom_range(spread) - spread / 2;
				default: g = roll(50) ? center : $urandom_range(255);
			endcase
			if (g < 0)
				g = 0;
			if (g > 255)
				g = 255;
			send_word(g[7:0], i == len - 1, 1'b0, none);
		end
	endtask

	initial begin
		int clips [6];
		hcrf_pkg::result_t none;
		none = '0;
		clips = '{0, 1, 256, 12800, 25600, 32767};
		pix.valid = 1'b0;
		pix.gray_pixel = '0;
		pix.last_pixel = 1'b0;
		clip_q8 = 256;
		clear_stats();
		repeat (3)
			@(negedge clk);
		arst_n = 1'b1;
		drain();

		// Directed part at the reset clip value, then with clipping off, then beyond full.
		add_row(0, 1, 1, 0, 0, 1);
		add_row(255, 1, 1, 255, 254, 0);
		add_row(0, 0, 0);
		add_row(255, 1, 0);
		add_row(128, 0, 0);
		add_row(3, 0, 0);
		add_row(200, 0, 0);
		add_row(77, 1, 0);
		foreach (dir_rows[i])
			send_word(dir_rows[i].gray, dir_rows[i].last, dir_rows[i].has_lit,
				dir_rows[i].lit);
		drain();
		dir_rows.delete();
		write_clip(0);
		add_row(17, 1, 1, 17, 17, 0);
		add_row(255, 0, 0);
		add_row(0, 0, 0);
		add_row(100, 1, 1, 0, 255, 0);
		add_row(200, 0, 0);
		add_row(50, 1, 1, 50, 200, 0);
		foreach (dir_rows[i])
			send_word(dir_rows[i].gray, dir_rows[i].last, dir_rows[i].has_lit,
				dir_rows[i].lit);
		drain();
		write_clip(32767);
		for (int i = 0; i < 8; i++)
			send_word(i * 36, i == 7, 1'b0, none);
		drain();

		// Random part: each clip setting in turn, then random ones, cycling through the idle profiles.
		for (int ph = 0; ph < 12; ph++) begin
			write_clip(ph < 6 ? clips[ph] : $urandom_range(32767));
			idle_mode = idle_mode_t'(ph % 4);
			while (word_count < 25 + (ph + 1) * 34) begin
				random_frame();
				// Hold the sender off until every pending result has come.
				if (roll(10)) begin
					pix.valid <= 1'b0;
					@(negedge clk);
					while (cuts_pending.size() != 0)
						@(negedge clk);
				end
			end
			drain();
		end
		idle_mode = IDLE_NONE;
		drain();

		$display("Covered %0d pixel words in %0d frames, %0d result words checked,",
			word_count, frame_count_done, result_count);
		$display("across clip values from zero to beyond full and four idle profiles.");
		if (fail_count == 0 && cuts_pending.size() == 0)
			$display("histogram_clip_range_finder test passed");
		else
			$display("histogram_clip_range_finder test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/hcrf_pkg.sv
rtl/hcrf_if.sv
rtl/hcrf_fifo.sv
rtl/hcrf_back.sv
rtl/histogram_clip_range_finder.sv
tb/sv/histogram_clip_range_finder_tb.sv
